@@ rtl/glw_pkg.sv @@
// shared types and constants for the greedy text line wrapper
`default_nettype none

package glw_pkg;

    // text offsets wrap at this width
    localparam int OFFSET_W = 16;

    localparam int CHAR_W   = 8;
    localparam int COLS_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int START_W  = 16;
    localparam int LEN_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [COLS_W-1:0]  COLS_RESET  = COLS_W'(41);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2048);

    localparam logic [CHAR_W-1:0] NL_CODE = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] SP_CODE = CHAR_W'(32);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = CFG_IDX_W'(1);

    // result queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                limit_reached;
        logic                run_last;
        logic [LEN_W-1:0]    line_length;
        logic [START_W-1:0]  line_start;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/greedy_text_line_wrapper.sv @@
// top level of the greedy text line wrapper
`default_nettype none

// Greedy text line wrapper. Text bytes enter one per item on the s_axis side
// and every visual line leaves as a start offset and a length on the m_axis
// side, with tlast set on the last line that one input item produced. A byte
// item is taken in every cycle as long as the four-entry result queue holds
// two results or fewer, and a line is written into the result queue when the
// item that ends it is taken. An item ends at most one line, except for a wrap
// followed by the end of the body, which puts two results in the queue. The
// output port drains one result per cycle while m_axis_tready is high, so the
// sustained rate is one item per cycle while items end at most one line each,
// and lower when every item closes two lines. The wrap decision is one pass of
// small counter logic from the state registers to the queue. The user must write
// columns and line_limit through the cfg port only while idle; the block does not check.

module greedy_text_line_wrapper (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration write port
    input  wire                              cfg_we,
    input  wire [glw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [glw_pkg::CFG_W-1:0]         cfg_data,
    // text byte items
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [7:0]                        s_axis_tdata,   // char_code
    input  wire [0:0]                        s_axis_tuser,   // char_present
    input  wire                              s_axis_tlast,   // text_end
    // line items
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // line_start, line_length
    output logic                             m_axis_tlast,   // run_last
    output logic [0:0]                       m_axis_tuser    // limit_reached
);
    import glw_pkg::*;

    // configuration registers
    logic [COLS_W-1:0]   columns_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // body tracking state
    logic [OFFSET_W-1:0] pos_reg,    pos_next;
    logic [OFFSET_W-1:0] start_reg,  start_next;
    logic [LEN_W-1:0]    count_reg,  count_next;
    logic [LEN_W-1:0]    spoff_reg,  spoff_next;
    logic                seen_reg,   seen_next;
    logic [LIMIT_W-1:0]  lines_reg,  lines_next;

    logic                in_fire;
    logic                present;
    logic [CHAR_W-1:0]   char_code;
    logic [COLS_W-1:0]   cols;
    logic                full;
    logic                is_nl;
    logic                add_char;
    logic [LEN_W-1:0]    base_count;

    // first line: ended by this byte
    logic                end_a;
    logic                emit_a;
    logic [START_W-1:0]  start_a;
    logic [LEN_W-1:0]    len_a;
    logic [LIMIT_W-1:0]  lines_a;

    // second line: pending text closed by the end of the body
    logic                emit_b;
    logic [LIMIT_W-1:0]  lines_b;

    res_t                res_a, res_b, first_item, out_item;
    logic                q_room, q_valid;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign present   = s_axis_tuser[0];
    assign char_code = s_axis_tdata;

    // zero columns act as one column
    assign cols  = (columns_reg == '0) ? COLS_W'(1) : columns_reg;
    // a line at or past the column count is full, also after columns drop
    assign full  = (count_reg >= cols);
    assign is_nl = (char_code == NL_CODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLS_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMNS:    columns_reg <= cfg_data[COLS_W-1:0];
                REG_LINE_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        count_next = count_reg;
        spoff_next = spoff_reg;
        seen_next  = seen_reg;
        end_a      = 1'b0;
        start_a    = start_reg;
        len_a      = count_reg;
        add_char   = 1'b0;
        base_count = count_reg;

        if (present)
        begin
            if (is_nl)
            begin
                // newline ends the line and is consumed
                end_a      = 1'b1;
                start_next = pos_reg + OFFSET_W'(1);
                count_next = '0;
                seen_next  = 1'b0;
                spoff_next = '0;
            end
            else if (full && seen_reg && (spoff_reg != '0))
            begin
                // break after the last space, carry the rest over
                end_a      = 1'b1;
                len_a      = spoff_reg;
                start_next = start_reg + OFFSET_W'(spoff_reg) + OFFSET_W'(1);
                base_count = count_reg - spoff_reg - LEN_W'(1);
                seen_next  = 1'b0;
                spoff_next = '0;
                add_char   = 1'b1;
            end
            else if (full)
            begin
                // hard cut at the column count
                end_a      = 1'b1;
                start_next = pos_reg;
                base_count = '0;
                seen_next  = 1'b0;
                spoff_next = '0;
                add_char   = 1'b1;
            end
            else
            begin
                add_char   = 1'b1;
            end

            if (add_char)
            begin
                if (char_code == SP_CODE)
                begin
                    spoff_next = base_count;
                    seen_next  = 1'b1;
                end
                count_next = base_count + LEN_W'(1);
            end
            pos_next = pos_reg + OFFSET_W'(1);
        end

        // line limit gating, counted in order of the two lines
        emit_a  = end_a && (lines_reg < limit_reg);
        lines_a = lines_reg + LIMIT_W'(emit_a);
        emit_b  = s_axis_tlast && (count_next != '0) && (lines_a < limit_reg);
        lines_b = lines_a + LIMIT_W'(emit_b);
        lines_next = lines_b;

        res_a.line_start    = start_a[START_W-1:0];
        res_a.line_length   = len_a;
        res_a.run_last      = !emit_b;
        res_a.limit_reached = (lines_a >= limit_reg);

        res_b.line_start    = start_next[START_W-1:0];
        res_b.line_length   = count_next;
        res_b.run_last      = 1'b1;
        res_b.limit_reached = (lines_b >= limit_reg);

        // end of body: back to a fresh body
        if (s_axis_tlast)
        begin
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
            spoff_next = '0;
            seen_next  = 1'b0;
            lines_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            spoff_reg <= '0;
            seen_reg  <= 1'b0;
            lines_reg <= '0;
        end
        else if (in_fire)
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            spoff_reg <= spoff_next;
            seen_reg  <= seen_next;
            lines_reg <= lines_next;
        end
    end

    // pack results so the first queue slot always holds the earlier line
    assign first_item = emit_a ? res_a : res_b;

    glw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (in_fire && (emit_a || emit_b)),
        .item_a    (first_item),
        .push_b    (in_fire && emit_a && emit_b),
        .item_b    (res_b),
        .pop       (m_axis_tready),
        .out_valid (q_valid),
        .out_item  (out_item),
        .room      (q_room)
    );

    assign s_axis_tready = q_room;
    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {out_item.line_length, out_item.line_start};
    assign m_axis_tlast  = out_item.run_last;
    assign m_axis_tuser  = out_item.limit_reached;

endmodule

`default_nettype wire

@@ rtl/glw_queue.sv @@
// result queue that takes up to two items per cycle and gives one
`default_nettype none

module glw_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_a,
    input  glw_pkg::res_t       item_a,
    input  wire                 push_b,
    input  glw_pkg::res_t       item_b,
    input  wire                 pop,
    output logic                out_valid,
    output glw_pkg::res_t       out_item,
    output logic                room
);
    import glw_pkg::*;

    res_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    // room for two more items, so one input can always be taken
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_a) + QPTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem_reg[wr_ptr_reg] <= item_a;
        end
        if (push_b)
        begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= item_b;
        end
    end

endmodule

`default_nettype wire

@@ rtl/glw_check.sv @@
// port-level checks for the greedy text line wrapper and their binding
`default_nettype none

module glw_check (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [23:0]                   m_axis_tdata,
    input wire                          m_axis_tlast,
    input wire [0:0]                    m_axis_tuser
);

    // a stalled line item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled line item changed");

    // lines only appear after a text item was taken
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("line item without a text item");

    // input is held off only while results wait
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result queue");

    // a result that is not last of its run is followed by the last one
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("first line of a pair not followed by its partner");

endmodule

bind greedy_text_line_wrapper glw_check u_glw_check (.*);

`default_nettype wire

@@ sim/glw_checker.sv @@
// line checker for the greedy text line wrapper: predicts every line and compares
`timescale 1ns / 100ps

module glw_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire [glw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [glw_pkg::CFG_W-1:0]      cfg_data,
    input  wire                           s_axis_tvalid,
    input  wire                           s_axis_tready,
    input  wire [7:0]                     s_axis_tdata,   // char_code
    input  wire [0:0]                     s_axis_tuser,   // char_present
    input  wire                           s_axis_tlast,   // text_end
    input  wire                           m_axis_tvalid,
    input  wire                           m_axis_tready,
    input  wire [23:0]                    m_axis_tdata,   // line_start, line_length
    input  wire                           m_axis_tlast,   // run_last
    input  wire [0:0]                     m_axis_tuser,   // limit_reached
    output int                            failures,
    output int                            lines_waiting,
    output int                            lines_checked,
    output int                            limit_flags
);
    import glw_pkg::*;

    logic [COLS_W-1:0]   cols_setting;
    logic [LIMIT_W-1:0]  limit_setting;

    logic [OFFSET_W-1:0] byte_pos;
    logic [OFFSET_W-1:0] line_head;
    logic [LEN_W-1:0]    pending_len;
    logic [LEN_W-1:0]    last_space;
    logic                space_found;
    logic [LIMIT_W-1:0]  lines_out;

    res_t expected_lines[$];
    res_t batch[$];

    task automatic clear_body();
        byte_pos    = '0;
        line_head   = '0;
        pending_len = '0;
        last_space  = '0;
        space_found = 1'b0;
        lines_out   = '0;
    endtask

    task automatic add_line(input logic [START_W-1:0] start, input logic [LEN_W-1:0] len);
        res_t entry;
        if (lines_out < limit_setting && batch.size() < 2)
        begin
            lines_out++;
            entry.line_start    = start;
            entry.line_length   = len;
            entry.run_last      = 1'b0;
            entry.limit_reached = (lines_out >= limit_setting);
            batch.push_back(entry);
        end
    endtask

    task automatic take_char(input logic [CHAR_W-1:0] code);
        if (code == SP_CODE)
        begin
            last_space  = pending_len;
            space_found = 1'b1;
        end
        pending_len++;
    endtask

    task automatic wrap_item(input logic [CHAR_W-1:0] code, input logic present,
                             input logic close);
        int width;
        logic [OFFSET_W-1:0] pos;
        res_t tail;
        width = (cols_setting == '0) ? 1 : int'(cols_setting);
        batch.delete();
        if (present)
        begin
            pos = byte_pos;
            if (code == NL_CODE)
            begin
                // newline ends the line whether full or not
                add_line(line_head, pending_len);
                line_head   = pos + 1'b1;
                pending_len = '0;
                space_found = 1'b0;
                last_space  = '0;
            end
            else if (pending_len >= width)
            begin
                if (space_found && last_space != '0)
                begin
                    add_line(line_head, last_space);
                    line_head   = line_head + OFFSET_W'(last_space) + 1'b1;
                    pending_len = pending_len - last_space - 1'b1;
                end
                else
                begin
                    // no usable space: hard cut at the present length
                    add_line(line_head, pending_len);
                    line_head   = pos;
                    pending_len = '0;
                end
                space_found = 1'b0;
                last_space  = '0;
                take_char(code);
            end
            else
            begin
                take_char(code);
            end
            byte_pos = pos + 1'b1;
        end
        if (close)
        begin
            if (pending_len != '0)
                add_line(line_head, pending_len);
            clear_body();
        end
        if (batch.size() != 0)
        begin
            tail = batch.pop_back();
            tail.run_last = 1'b1;
            batch.push_back(tail);
        end
        foreach (batch[i])
            expected_lines.push_back(batch[i]);
    endtask

    task automatic check_line();
        res_t want;
        logic [START_W-1:0] got_start;
        logic [LEN_W-1:0]   got_len;
        logic               got_last;
        logic               got_limit;
        got_start = m_axis_tdata[15:0];
        got_len   = m_axis_tdata[23:16];
        got_last  = m_axis_tlast;
        got_limit = m_axis_tuser[0];
        lines_checked++;
        if (got_limit)
            limit_flags++;
        if (expected_lines.size() == 0)
        begin
            $error("unexpected line: start %0d length %0d", got_start, got_len);
            failures++;
        end
        else
        begin
            want = expected_lines.pop_front();
            if (got_start !== want.line_start)
            begin
                $error("line_start: expected %0d, got %0d", want.line_start, got_start);
                failures++;
            end
            if (got_len !== want.line_length)
            begin
                $error("line_length: expected %0d, got %0d", want.line_length, got_len);
                failures++;
            end
            if (got_last !== want.run_last)
            begin
                $error("run_last: expected %0b, got %0b", want.run_last, got_last);
                failures++;
            end
            if (got_limit !== want.limit_reached)
            begin
                $error("limit_reached: expected %0b, got %0b", want.limit_reached, got_limit);
                failures++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_setting  = COLS_RESET;
            limit_setting = LIMIT_RESET;
            clear_body();
            expected_lines.delete();
            failures      = 0;
            lines_waiting = 0;
            lines_checked = 0;
            limit_flags   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_line();
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COLUMNS:    cols_setting = cfg_data[COLS_W-1:0];
                    REG_LINE_LIMIT: limit_setting = cfg_data[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                wrap_item(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            lines_waiting = expected_lines.size();
        end
    end

endmodule

@@ sim/greedy_text_line_wrapper_test.sv @@
// testbench top for the greedy text line wrapper: stimulus, stalls and verdict
`timescale 1ns / 100ps

module greedy_text_line_wrapper_test;
    import glw_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    // total text items over the whole run, directed part included
    localparam int TARGET_ITEMS  = 950;
    // the wrap decision is one pass from state to queue, so after the last line
    // and this settle time the block is certainly idle
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // long receiver hold-off so the four-entry queue fills and input stalls
    localparam int HOLD_CYCLES   = 200;
    // worst case is far below this: ~1000 items, two lines each, short stalls
    localparam int CYCLE_LIMIT   = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // char_code
    logic [0:0]            s_axis_tuser;   // char_present
    logic                  s_axis_tlast;   // text_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // line_start, line_length
    logic                  m_axis_tlast;   // run_last
    logic [0:0]            m_axis_tuser;   // limit_reached

    int failures;
    int lines_waiting;
    int lines_checked;
    int limit_flags;

    // stimulus bookkeeping
    int  items_sent;
    int  bodies_closed;
    int  phases;
    int  cols_now;
    bit  gaps_on;
    int  hold_requests;
    int  cycle_count;

    greedy_text_line_wrapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    glw_checker line_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .lines_waiting (lines_waiting),
        .lines_checked (lines_checked),
        .limit_flags   (limit_flags)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("greedy_text_line_wrapper_test: errors");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : line_sink
        int holds_done;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 8);
        end
    end

    // offer one item and hold it until the block takes it; tvalid stays high
    // afterwards, so back-to-back items keep it high unless a random gap is drawn
    task automatic send_item(input logic [7:0] code, input logic present,
                             input logic close);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= code;
        s_axis_tuser[0] <= present;
        s_axis_tlast    <= close;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // a byte-less item without text_end does nothing, so it is not counted
        if (present || close)
            items_sent++;
        if (close)
            bodies_closed++;
    endtask

    task automatic send_text(input string text, input bit close);
        for (int i = 0; i < text.len(); i++)
            send_item(text[i], 1'b1, close && (i == text.len() - 1));
    endtask

    // drop tvalid, wait for every predicted line, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (lines_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register writes only happen from an idle block
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_COLUMNS)
            cols_now = (value == 0) ? 1 : value;
    endtask

    // mostly printable word bytes, some raw bytes so every bit toggles
    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(33, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    // narrow widths wrap often; the extremes show up now and then
    function automatic int pick_columns();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 1;
        if (r < 18)
            return 255;
        if (r < 70)
            return $urandom_range(2, 12);
        return $urandom_range(13, 60);
    endfunction

    function automatic int pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 65535;
        if (r < 45)
            return $urandom_range(1, 4);
        return $urandom_range(200, 65535);
    endfunction

    // a well-formed body of words with random content and separators; a few
    // separators are noise bytes or ignored items, and some bodies stay open
    // across the next register change
    task automatic random_body();
        int words;
        int wlen;
        int cap;
        int style;
        cap   = (cols_now + 2 > 30) ? 30 : cols_now + 2;
        words = $urandom_range(1, 8);
        for (int w = 0; w < words; w++)
        begin
            wlen = $urandom_range(1, cap);
            for (int k = 0; k < wlen; k++)
                send_item(text_byte(), 1'b1, 1'b0);
            style = $urandom_range(0, 99);
            if (style < 68)
                send_item(SP_CODE, 1'b1, 1'b0);
            else if (style < 78)
            begin
                send_item(SP_CODE, 1'b1, 1'b0);
                send_item(SP_CODE, 1'b1, 1'b0);
            end
            else if (style < 90)
                send_item(NL_CODE, 1'b1, 1'b0);
            else if (style < 96)
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        style = $urandom_range(0, 99);
        if (style < 40)
            send_item(text_byte(), 1'b1, 1'b1);
        else if (style < 70)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);   // close-only item
        else if (style < 85)
            send_item(NL_CODE, 1'b1, 1'b1);                      // trailing newline
    endtask

    initial
    begin : stimulus
        int bodies;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_COLUMNS;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        gaps_on       = 1'b1;
        hold_requests = 0;
        items_sent    = 0;
        bodies_closed = 0;
        phases        = 0;
        cols_now      = int'(COLS_RESET);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: four columns, highest line limit
        set_reg(REG_COLUMNS, 4);
        set_reg(REG_LINE_LIMIT, 65535);
        send_text("ab cdef", 1'b0);      // break after a space
        send_text(" wxyz", 1'b0);        // hard cut, then a space as first character
        send_text("abc\n", 1'b0);        // newline arriving on a full line
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);    // close-only item ends the body
        send_item(8'hFF, 1'b0, 1'b1);    // empty body
        send_text("k\n", 1'b1);          // trailing newline adds no line
        send_text("abc", 1'b0);
        // columns lowered under a pending line; one item then ends two lines
        set_reg(REG_COLUMNS, 1);
        send_text("d", 1'b1);
        // receiver holds off while one-column lines keep coming: the queue
        // fills up and the input stalls
        hold_requests++;
        send_text("stall test", 1'b1);
        // zero columns and zero limit: nothing comes out
        set_reg(REG_COLUMNS, 0);
        set_reg(REG_LINE_LIMIT, 0);
        send_text("x", 1'b1);
        // limit of one: first line flagged, the rest of the body suppressed
        set_reg(REG_LINE_LIMIT, 1);
        send_text("p q", 1'b1);

        // random phases, each under a fresh register setting
        while (items_sent < TARGET_ITEMS)
        begin
            phases++;
            set_reg(REG_COLUMNS, pick_columns());
            if (phases == 1 || $urandom_range(0, 2) == 0)
                set_reg(REG_LINE_LIMIT, pick_limit());
            // a long stretch with no idling on either side
            gaps_on = !(phases >= 6 && phases < 10);
            if (phases == 3)
                hold_requests++;
            bodies = $urandom_range(1, 2);
            repeat (bodies) random_body();
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d text items in %0d bodies over %0d random settings",
                 items_sent, bodies_closed, phases);
        $display("compared %0d lines, %0d of them flagged at the line limit",
                 lines_checked, limit_flags);
        if (failures == 0)
            $display("greedy_text_line_wrapper_test: clean");
        else
            $display("greedy_text_line_wrapper_test: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/glw_pkg.sv
rtl/glw_queue.sv
rtl/greedy_text_line_wrapper.sv
rtl/glw_check.sv
sim/glw_checker.sv
sim/greedy_text_line_wrapper_test.sv
